// ----- rtl/utf8_ascii_transliterator_assert.svh -----
// ---------------------------------------------------------------------------
// utf8_ascii_transliterator assertion macros
// Clocked, reset-qualified property checks shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_ASCII_TRANSLITERATOR_ASSERT_SVH
`define UTF8_ASCII_TRANSLITERATOR_ASSERT_SVH

// Same-cycle implication under clk_i, idle during reset.
`define UTAT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8_ascii_transliterator: check failed");

// Next-cycle implication under clk_i, idle during reset.
`define UTAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8_ascii_transliterator: check failed");

`endif

// ----- rtl/utat_pkg.sv -----
// ---------------------------------------------------------------------------
// utat_pkg
// Shared types, constants and the punctuation lookup of the transliterator.
// ---------------------------------------------------------------------------
package utat_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CAP_W      = 16;
  localparam int CP_W       = 21;
  localparam int SUM_W      = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  // Register map (word index)
  localparam logic REG_CAPACITY = 1'b0;

  // UTF-8 lead and continuation classes
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_BAD   = 8'hF8;
  localparam logic [7:0] PAY_LEAD2  = 8'h1F;
  localparam logic [7:0] PAY_LEAD3  = 8'h0F;
  localparam logic [7:0] PAY_LEAD4  = 8'h07;
  localparam logic [7:0] PAY_CONT   = 8'h3F;

  // ASCII replacement characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_M      = 8'h4D;

  typedef struct packed {
    logic             hit;
    logic [2:0]       len;
    logic [3:0][7:0]  text;   // text[0] goes out first
  } punct_t;

  // Results caused by one input item
  typedef struct packed {
    logic [3:0][7:0]  bytes;  // bytes[0] goes out first
    logic [2:0]       count;  // 0 to 4
    logic             term;   // last result is the terminator
  } res_t;

  // Decoder status for checks
  typedef struct packed {
    logic [1:0] held_count;
    logic [2:0] seq_len;
    logic       stopped;
  } dec_stat_t;

  function automatic punct_t punct_lookup(input logic [CP_W-1:0] cp);
    punct_t e;
    e = '0;
    case (cp) inside
      21'h0000A0: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_SPACE;
      end
      21'h002010, 21'h002011, 21'h002012, 21'h002013, 21'h002014, 21'h002015,
      21'h002022: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_DASH;
      end
      21'h002018, 21'h002019, 21'h00201A, 21'h00201B, 21'h002032: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_APOS;
      end
      21'h00201C, 21'h00201D, 21'h00201E, 21'h00201F, 21'h002033: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_QUOTE;
      end
      21'h002024: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_DOT;
      end
      21'h002025: begin
        e.hit = 1'b1; e.len = 3'd2; e.text[0] = CH_DOT; e.text[1] = CH_DOT;
      end
      21'h002026: begin
        e.hit = 1'b1; e.len = 3'd3;
        e.text[0] = CH_DOT; e.text[1] = CH_DOT; e.text[2] = CH_DOT;
      end
      21'h002039: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_LT;
      end
      21'h00203A: begin
        e.hit = 1'b1; e.len = 3'd1; e.text[0] = CH_GT;
      end
      21'h002122: begin
        e.hit = 1'b1; e.len = 3'd4;
        e.text[0] = CH_LPAREN; e.text[1] = CH_T; e.text[2] = CH_M; e.text[3] = CH_RPAREN;
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/utf8_ascii_transliterator.sv -----
// The first result of an item is registered and valid in the cycle after the item is accepted.
// Input takes one byte per cycle while each byte gives at most one result and the
// output is not stalled; a byte giving more results (up to 4) holds the input until
// the four-byte result register has handed out all but the last of them, one per handshake.
// Reset: capacity returns to 256, sequence state, count and stop flag clear.
// ---------------------------------------------------------------------------
// utf8_ascii_transliterator
// UTF-8 to ASCII punctuation transliterator with an APB capacity register.
// ---------------------------------------------------------------------------
`include "utf8_ascii_transliterator_assert.svh"

module utf8_ascii_transliterator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tlast,    // run_last
  output logic        m_axis_tuser,    // [0] string_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [utat_pkg::CAP_W-1:0] cap_q;
  logic                       accept;
  logic                       can_load;
  utat_pkg::res_t             res;
  utat_pkg::dec_stat_t        stat;

  // Capacity register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == utat_pkg::REG_CAPACITY) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= utat_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == utat_pkg::REG_CAPACITY) begin
      cap_q <= pwdata[utat_pkg::CAP_W-1:0];
    end
  end

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  utat_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .byte_i (s_axis_tdata),
    .cap_i  (cap_q),
    .res_o  (res),
    .stat_o (stat)
  );

  utat_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .res_i         (res),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Checks
  `UTAT_ASSERT_IMPL(a_term_is_nul_last,
    m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'h00 && m_axis_tlast)
  `UTAT_ASSERT_IMPL(a_held_in_range,
    stat.held_count != 2'd0,
    stat.seq_len >= 3'd2 && stat.seq_len <= 3'd4 && {1'b0, stat.held_count} < stat.seq_len)
  `UTAT_ASSERT_IMPL(a_stopped_holds_nothing, stat.stopped, stat.held_count == 2'd0)
  `UTAT_ASSERT_NEXT(a_nul_gives_result,
    accept && s_axis_tdata == 8'h00 && cap_q != '0, m_axis_tvalid)

endmodule

// ----- rtl/utat_decode.sv -----
// ---------------------------------------------------------------------------
// utat_decode
// Sequence state and single-pass decode of one byte into up to four results.
// ---------------------------------------------------------------------------
module utat_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [7:0]                    byte_i,
  input  logic [utat_pkg::CAP_W-1:0]    cap_i,
  output utat_pkg::res_t                res_o,
  output utat_pkg::dec_stat_t           stat_o
);

  logic [2:0][7:0]                   held_q, held_d;
  logic [1:0]                        hc_q, hc_d;
  logic [2:0]                        sl_q, sl_d;
  logic [utat_pkg::CP_W-1:0]         cp_q, cp_d;
  logic [utat_pkg::COUNT_BITS-1:0]   wc_q, wc_d;
  logic                              stop_q, stop_d;

  logic [4:1]                        fit;
  logic [1:0]                        max_fit;
  logic [1:0]                        flush_n;
  logic [utat_pkg::CP_W-1:0]         cp_ext;
  utat_pkg::punct_t                  ent;
  utat_pkg::res_t                    res;
  logic                              do_fresh;
  logic [1:0]                        base;
  logic                              is_plain;
  logic                              is_cont;

  // Fit test: written + n + 1 <= capacity, for n = 1..4
  always_comb begin
    for (int n = 1; n <= 4; n++) begin
      fit[n] = !stop_q &&
               ((utat_pkg::SUM_W'(wc_q) + utat_pkg::SUM_W'(n + 1)) <=
                utat_pkg::SUM_W'(cap_i));
    end
  end

  // Number of held bytes that can be flushed raw
  assign max_fit = fit[3] ? 2'd3 : (fit[2] ? 2'd2 : (fit[1] ? 2'd1 : 2'd0));
  assign flush_n = (hc_q < max_fit) ? hc_q : max_fit;

  assign cp_ext   = {cp_q[utat_pkg::CP_W-7:0], byte_i[5:0]};
  assign ent      = utat_pkg::punct_lookup(cp_ext);
  assign is_cont  = (byte_i & utat_pkg::MASK_CONT) == utat_pkg::CODE_CONT;
  assign is_plain = !byte_i[7] || is_cont ||
                    ((byte_i & utat_pkg::MASK_BAD) == utat_pkg::MASK_BAD);

  // Next state and results for the byte at the input
  always_comb begin
    held_d   = held_q;
    hc_d     = hc_q;
    sl_d     = sl_q;
    cp_d     = cp_q;
    wc_d     = wc_q;
    stop_d   = stop_q;
    res      = '0;
    do_fresh = 1'b0;
    base     = 2'd0;

    if (byte_i == 8'h00) begin
      // End of string: flush held bytes that fit, then the terminator if capacity is nonzero
      if (!stop_q) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < flush_n) res.bytes[i] = held_q[i];
        end
        res.count = {1'b0, flush_n};
      end
      if (cap_i != '0) begin
        res.bytes[res.count[1:0]] = 8'h00;
        res.count = res.count + 3'd1;
        res.term  = 1'b1;
      end
      held_d = '0; hc_d = '0; sl_d = '0; cp_d = '0;
      wc_d   = '0;
      stop_d = 1'b0;
    end else if (stop_q) begin
      // Drop everything until the terminator
      held_d = '0; hc_d = '0; sl_d = '0; cp_d = '0;
    end else if (hc_q != 2'd0 && sl_q >= 3'd2 && sl_q <= 3'd4) begin
      if (is_cont) begin
        cp_d = cp_ext;
        if (({1'b0, hc_q} + 3'd1) >= sl_q) begin
          // Sequence complete: replace or copy whole
          if (ent.hit) begin
            if (fit[ent.len]) begin
              res.bytes = ent.text;
              res.count = ent.len;
              wc_d      = wc_q + utat_pkg::COUNT_BITS'(ent.len);
            end else begin
              stop_d = 1'b1;
            end
          end else if (fit[sl_q]) begin
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < hc_q) res.bytes[i] = held_q[i];
            end
            res.bytes[hc_q] = byte_i;
            res.count       = {1'b0, hc_q} + 3'd1;
            wc_d            = wc_q + utat_pkg::COUNT_BITS'({1'b0, hc_q} + 3'd1);
          end else begin
            stop_d = 1'b1;
          end
          held_d = '0; hc_d = '0; sl_d = '0; cp_d = '0;
        end else if (hc_q < 2'd3) begin
          held_d[hc_q] = byte_i;
          hc_d         = hc_q + 2'd1;
        end
      end else begin
        // Malformed: copy held bytes raw, then decode this byte afresh if all of them fit
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < flush_n) res.bytes[i] = held_q[i];
        end
        res.count = {1'b0, flush_n};
        wc_d      = wc_q + utat_pkg::COUNT_BITS'(flush_n);
        held_d = '0; hc_d = '0; sl_d = '0; cp_d = '0;
        if (flush_n != hc_q) begin
          stop_d = 1'b1;
        end else begin
          do_fresh = 1'b1;
          base     = flush_n;
        end
      end
    end else begin
      held_d = '0; hc_d = '0; sl_d = '0; cp_d = '0;
      do_fresh = 1'b1;
    end

    // Fresh decode: copy a single byte or start a sequence
    if (do_fresh) begin
      if (is_plain) begin
        if (fit[{1'b0, base} + 3'd1]) begin
          res.bytes[base] = byte_i;
          res.count       = {1'b0, base} + 3'd1;
          wc_d            = wc_q + utat_pkg::COUNT_BITS'({1'b0, base} + 3'd1);
        end else begin
          stop_d = 1'b1;
        end
      end else begin
        held_d[0] = byte_i;
        hc_d      = 2'd1;
        if ((byte_i & utat_pkg::MASK_LEAD2) == utat_pkg::CODE_LEAD2) begin
          sl_d = 3'd2;
          cp_d = utat_pkg::CP_W'(byte_i & utat_pkg::PAY_LEAD2);
        end else if ((byte_i & utat_pkg::MASK_LEAD3) == utat_pkg::CODE_LEAD3) begin
          sl_d = 3'd3;
          cp_d = utat_pkg::CP_W'(byte_i & utat_pkg::PAY_LEAD3);
        end else begin
          sl_d = 3'd4;
          cp_d = utat_pkg::CP_W'(byte_i & utat_pkg::PAY_LEAD4);
        end
      end
    end
  end

  // Advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      hc_q   <= '0;
      sl_q   <= '0;
      cp_q   <= '0;
      wc_q   <= '0;
      stop_q <= 1'b0;
    end else if (load_i) begin
      held_q <= held_d;
      hc_q   <= hc_d;
      sl_q   <= sl_d;
      cp_q   <= cp_d;
      wc_q   <= wc_d;
      stop_q <= stop_d;
    end
  end

  assign res_o             = res;
  assign stat_o.held_count = hc_q;
  assign stat_o.seq_len    = sl_q;
  assign stat_o.stopped    = stop_q;

endmodule

// ----- rtl/utat_emit.sv -----
// ---------------------------------------------------------------------------
// utat_emit
// Result register that hands out the results of one item, one per cycle while the output is ready.
// ---------------------------------------------------------------------------
module utat_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  utat_pkg::res_t  res_i,
  output logic            can_load_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // run_last
  output logic            m_axis_tuser    // [0] string_end
);

  logic [3:0][7:0] buf_q;
  logic            term_q;
  logic [2:0]      rem_q;
  logic [1:0]      pos_q;
  logic            take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = rem_q != 3'd0;
  assign m_axis_tdata  = buf_q[pos_q];
  assign m_axis_tlast  = rem_q == 3'd1;
  assign m_axis_tuser  = term_q && (rem_q == 3'd1);

  // Free once empty or while the final result leaves
  assign can_load_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);

  // Hold results; advance one per handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pos_q <= '0;
    end else if (load_i) begin
      rem_q <= res_i.count;
      pos_q <= '0;
    end else if (take) begin
      rem_q <= rem_q - 3'd1;
      pos_q <= pos_q + 2'd1;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= res_i.bytes;
      term_q <= res_i.term;
    end
  end

endmodule
